### hw/rtl/ctlt_pkg.sv
package ctlt_pkg;

   // queue between front and back
   localparam int QDepth = 2;
   localparam int QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;

   // one output job: up to four bytes, sent from index 0 to last_idx
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } job_type;

   // Latin spelling of one letter, c0 first
   typedef struct packed {
      logic [1:0] len;
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
   } spell_type;

   localparam logic [7:0] Nul      = 8'h00;
   localparam logic [7:0] CaseDiff = 8'h20;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] n;
      if (!b[7])                    n = 3'd1;
      else if (b[7:5] == 3'b110)    n = 3'd2;
      else if (b[7:4] == 4'b1110)   n = 3'd3;
      else if (b[7:3] == 5'b11110)  n = 3'd4;
      else                          n = 3'd1;
      return n;
   endfunction

   function automatic spell_type spell(input logic [4:0] idx);
      spell_type s;
      case (idx)
         5'd0:    s = '{2'd1, "a", Nul, Nul};
         5'd1:    s = '{2'd1, "b", Nul, Nul};
         5'd2:    s = '{2'd1, "v", Nul, Nul};
         5'd3:    s = '{2'd1, "g", Nul, Nul};
         5'd4:    s = '{2'd1, "d", Nul, Nul};
         5'd5:    s = '{2'd1, "e", Nul, Nul};
         5'd6:    s = '{2'd2, "z", "h", Nul};
         5'd7:    s = '{2'd1, "z", Nul, Nul};
         5'd8:    s = '{2'd1, "i", Nul, Nul};
         5'd9:    s = '{2'd1, "y", Nul, Nul};
         5'd10:   s = '{2'd1, "k", Nul, Nul};
         5'd11:   s = '{2'd1, "l", Nul, Nul};
         5'd12:   s = '{2'd1, "m", Nul, Nul};
         5'd13:   s = '{2'd1, "n", Nul, Nul};
         5'd14:   s = '{2'd1, "o", Nul, Nul};
         5'd15:   s = '{2'd1, "p", Nul, Nul};
         5'd16:   s = '{2'd1, "r", Nul, Nul};
         5'd17:   s = '{2'd1, "s", Nul, Nul};
         5'd18:   s = '{2'd1, "t", Nul, Nul};
         5'd19:   s = '{2'd1, "u", Nul, Nul};
         5'd20:   s = '{2'd1, "f", Nul, Nul};
         5'd21:   s = '{2'd2, "k", "h", Nul};
         5'd22:   s = '{2'd2, "t", "s", Nul};
         5'd23:   s = '{2'd2, "c", "h", Nul};
         5'd24:   s = '{2'd2, "s", "h", Nul};
         5'd25:   s = '{2'd3, "s", "c", "h"};
         5'd26:   s = '{2'd0, Nul, Nul, Nul};
         5'd27:   s = '{2'd1, "y", Nul, Nul};
         5'd28:   s = '{2'd0, Nul, Nul, Nul};
         5'd29:   s = '{2'd1, "e", Nul, Nul};
         5'd30:   s = '{2'd2, "y", "u", Nul};
         5'd31:   s = '{2'd2, "y", "a", Nul};
         default: s = '{2'd0, Nul, Nul, Nul};
      endcase
      return s;
   endfunction

endpackage

### hw/rtl/ctlt_front.sv
module ctlt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_eot,
   output logic              in_ready,
   input  logic              q_full,
   output logic              q_push,
   output ctlt_pkg::job_type q_data
);
   import ctlt_pkg::*;

   logic [1:0] pend_cnt_ff, pend_cnt_in;
   logic [2:0] exp_len_ff, exp_len_in;
   logic [7:0] pend_ff [3];

   logic       take;
   logic [2:0] exp_len;
   logic [2:0] have;
   logic       complete;
   logic [3:0][7:0] chr;
   logic       hit, upper;
   logic [4:0] idx;
   logic [7:0] lead, sec;
   spell_type  sp;
   job_type    raw_job, sp_job;

   assign in_ready = !q_full;
   assign take     = in_valid && in_ready;

   assign exp_len  = (pend_cnt_ff == 2'd0) ? lead_length(in_byte) : exp_len_ff;
   assign have     = {1'b0, pend_cnt_ff} + 3'd1;
   assign complete = have >= exp_len;

   // held bytes first, then the new byte; the fourth slot only ever holds the new byte
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (k < int'(pend_cnt_ff)) chr[k] = pend_ff[k];
         else if (k == int'(pend_cnt_ff)) chr[k] = in_byte;
         else chr[k] = Nul;
      end
      chr[3] = (pend_cnt_ff == 2'd3) ? in_byte : Nul;
   end

   // Russian letter decode, two-byte characters only
   assign lead = pend_ff[0];
   assign sec  = in_byte;
   always_comb begin
      hit   = 1'b0;
      upper = 1'b0;
      idx   = 5'd0;
      if (have == 3'd2 && lead == 8'hD0) begin
         if (sec >= 8'h90 && sec <= 8'hAF) begin
            hit = 1'b1; upper = 1'b1; idx = 5'(sec - 8'h90);
         end else if (sec >= 8'hB0 && sec <= 8'hBF) begin
            hit = 1'b1; idx = 5'(sec - 8'hB0);
         end else if (sec == 8'h81) begin
            hit = 1'b1; upper = 1'b1; idx = 5'd5;
         end
      end else if (have == 3'd2 && lead == 8'hD1) begin
         if (sec >= 8'h80 && sec <= 8'h8F) begin
            hit = 1'b1; idx = 5'(sec - 8'h80) + 5'd16;
         end else if (sec == 8'h91) begin
            hit = 1'b1; idx = 5'd5;
         end
      end
   end

   assign sp = spell(idx);

   always_comb begin
      raw_job.bytes    = chr;
      raw_job.last_idx = 2'(have - 3'd1);
      sp_job.bytes[0]  = upper ? (sp.c0 - CaseDiff) : sp.c0;
      sp_job.bytes[1]  = sp.c1;
      sp_job.bytes[2]  = sp.c2;
      sp_job.bytes[3]  = Nul;
      sp_job.last_idx  = sp.len - 2'd1;
   end

   // hard and soft signs spell to nothing: no job
   assign q_push = take && (complete || in_eot) && !(complete && hit && sp.len == 2'd0);
   assign q_data = (complete && hit) ? sp_job : raw_job;

   always_comb begin
      pend_cnt_in = pend_cnt_ff;
      exp_len_in  = exp_len_ff;
      if (take) begin
         if (complete || in_eot) begin
            pend_cnt_in = 2'd0;
            exp_len_in  = 3'd0;
         end else begin
            pend_cnt_in = have[1:0];
            exp_len_in  = exp_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
         exp_len_ff  <= 3'd0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         exp_len_ff  <= exp_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !complete && !in_eot && pend_cnt_ff != 2'd3) begin
         pend_ff[pend_cnt_ff] <= in_byte;
      end
   end

endmodule

### hw/rtl/ctlt_queue.sv
module ctlt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ctlt_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output ctlt_pkg::job_type pop_data,
   output logic              empty
);
   import ctlt_pkg::*;

   localparam int CntW = $clog2(QDepth + 1);

   job_type         mem_ff [QDepth];
   logic [QAw-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QAw-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full     = cnt_ff == CntW'(QDepth);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   function automatic logic [QAw-1:0] bump(input logic [QAw-1:0] p);
      return (p == QAw'(QDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ctlt_back.sv
module ctlt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  ctlt_pkg::job_type q_data,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              out_last
);
   import ctlt_pkg::*;

   job_type    job_ff, job_in;
   logic [1:0] pos_ff, pos_in;
   logic       busy_ff, busy_in;
   logic       take, done;

   assign out_valid = busy_ff;
   assign out_byte  = job_ff.bytes[pos_ff];
   assign out_last  = pos_ff == job_ff.last_idx;

   assign take  = busy_ff && out_ready;
   assign done  = !busy_ff || (take && out_last);
   assign q_pop = done && !q_empty;

   always_comb begin
      job_in  = job_ff;
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         job_in  = q_data;
         pos_in  = 2'd0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (take) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

### hw/rtl/cyrillic_latin_transliterator_core.sv
// Cyrillic to Latin transliterator, UTF-8 in, one byte per item each side.
// The item that completes a character is written into the job queue, then
// loaded into the back end before its first output byte is valid.
// Throughput: one input item per cycle while the 2-entry job queue has room;
// output is one byte per cycle while the receiver is ready. Reset clears
// gather state, queue and output valid.
module cyrillic_latin_transliterator_core (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // end_of_text
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // last_of_run
);
   import ctlt_pkg::*;

   // front -> queue
   logic    q_push;
   job_type q_wdata;
   logic    q_full;
   // queue -> back
   logic    q_pop;
   job_type q_rdata;
   logic    q_empty;

   // Front: gathers bytes into characters, decodes Russian letters and
   // builds a job of 1..4 output bytes. Hard/soft signs make no job.
   ctlt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_eot   (req_tlast),
      .in_ready (req_tready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   // Short job queue decouples input stalls from output stalls.
   ctlt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   // Back: walks each job one byte per item, tlast on the job's last byte.
   ctlt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // front never writes a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   // a job with bytes left keeps the output valid
   a_job_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("output dropped mid-job");

   // nothing is shown right after a reset cycle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // the back end only pops a job when the queue holds one
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");
`endif

endmodule

### tb/cyrillic_latin_transliterator_core_tb.sv
module cyrillic_latin_transliterator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HalfPeriod   = 10;
   localparam int ResetCycles  = 4;
   localparam int CycleLimit   = 200_000;
   localparam int SettleCycles = 50;
   localparam int HoldOffCycles = 300;
   localparam int PhaseItems   = 82;

   typedef logic [7:0] octet_type;
   typedef octet_type octet_q_type[$];

   // Expected output bytes of the transliterator, oldest first.
   class translit_scoreboard;
      typedef struct {
         octet_type out_byte;
         logic      last_of_run;
      } out_item_type;

      out_item_type expected_q[$];
      octet_type    held[3];
      logic [1:0]   held_cnt;
      logic [2:0]   char_len;
      string        latin_lc[32];
      int           errors;

      function new();
         latin_lc = '{"a", "b", "v", "g", "d", "e", "zh", "z", "i", "y", "k",
                      "l", "m", "n", "o", "p", "r", "s", "t", "u", "f", "kh",
                      "ts", "ch", "sh", "sch", "", "y", "", "e", "yu", "ya"};
         held     = '{default: 8'h00};
         held_cnt = 2'd0;
         char_len = 3'd0;
         errors   = 0;
      endfunction

      // character length announced by a lead byte; stray bytes count as one
      function logic [2:0] char_length(octet_type b);
         casez (b)
            8'b0???????: return 3'd1;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            default:     return 3'd1;
         endcase
      endfunction

      function void push_bytes(octet_q_type bytes);
         out_item_type it;
         foreach (bytes[k]) begin
            it.out_byte    = bytes[k];
            it.last_of_run = (k == bytes.size() - 1);
            expected_q.push_back(it);
         end
      endfunction

      // Latin spelling of a complete character, or its own bytes if it is
      // not a Russian letter
      function void spell_char(input octet_q_type chr, output octet_q_type res);
         int        idx;
         bit        upper;
         octet_type c;
         idx   = -1;
         upper = 1'b0;
         res   = {};
         if (chr.size() == 2 && chr[0] == 8'hD0) begin
            if (chr[1] >= 8'h90 && chr[1] <= 8'hAF) begin
               idx   = int'(chr[1]) - 'h90;
               upper = 1'b1;
            end else if (chr[1] >= 8'hB0 && chr[1] <= 8'hBF) begin
               idx = int'(chr[1]) - 'hB0;
            end else if (chr[1] == 8'h81) begin
               idx   = 5;
               upper = 1'b1;
            end
         end else if (chr.size() == 2 && chr[0] == 8'hD1) begin
            if (chr[1] >= 8'h80 && chr[1] <= 8'h8F) idx = int'(chr[1]) - 'h80 + 16;
            else if (chr[1] == 8'h91) idx = 5;
         end
         if (idx < 0) begin
            res = chr;
         end else begin
            for (int k = 0; k < latin_lc[idx].len(); k++) begin
               c = latin_lc[idx][k];
               if (upper && k == 0) c = c - 8'h20;
               res.push_back(c);
            end
         end
      endfunction

      function void note_input(octet_type b, logic eot);
         octet_q_type chr;
         octet_q_type res;
         if (held_cnt == 2'd0) char_len = char_length(b);
         for (int k = 0; k < held_cnt; k++) chr.push_back(held[k]);
         chr.push_back(b);
         if (chr.size() >= char_len) begin
            held_cnt = 2'd0;
            char_len = 3'd0;
            spell_char(chr, res);
            push_bytes(res);
         end else if (eot) begin
            // end of text mid-character: flush what was gathered
            held_cnt = 2'd0;
            char_len = 3'd0;
            push_bytes(chr);
         end else begin
            held[chr.size() - 1] = b;
            held_cnt = 2'(chr.size());
         end
      endfunction

      function void check_output(octet_type b, logic last);
         out_item_type it;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected output item: expected none, actual byte %02h last %0b",
                     $time, b, last);
            errors++;
            return;
         end
         it = expected_q.pop_front();
         if (it.out_byte !== b) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, it.out_byte, b);
            errors++;
         end
         if (it.last_of_run !== last) begin
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, it.last_of_run, last);
            errors++;
         end
      endfunction
   endclass

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_tvalid = 1'b0;
   logic      req_tready;
   octet_type req_tdata  = 8'h00;
   logic      req_tlast  = 1'b0;
   logic      rsp_tvalid;
   logic      rsp_tready = 1'b0;
   octet_type rsp_tdata;
   logic      rsp_tlast;

   translit_scoreboard sb;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_req      = 0;
   int  hold_left     = 0;
   int  sent_cnt      = 0;
   int  cycle_cnt     = 0;

   cyrillic_latin_transliterator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(HalfPeriod) clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always begin
      @(negedge clock);
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_output(rsp_tdata, rsp_tlast);
   end

   // random byte in [lo, hi]
   function automatic octet_type rnd_octet(int unsigned hi, int unsigned lo = 0);
      return octet_type'($urandom_range(hi, lo));
   endfunction

   // one text byte; called and returns at a falling edge
   task automatic send_byte(input octet_type b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      sb.note_input(b, eot);
      sent_cnt++;
      @(negedge clock);
   endtask

   // mostly well-formed characters with random content, some noise and
   // some sequences cut short by end of text
   task automatic send_random_char();
      octet_q_type bytes;
      bit          eot_end;
      int          kind;
      int          r;
      int          conts;
      kind    = $urandom_range(99);
      eot_end = ($urandom_range(99) < 8);
      if (kind < 45) begin
         r = $urandom_range(65);
         if (r < 32)       bytes = '{8'hD0, octet_type'(8'h90 + r)};
         else if (r < 48)  bytes = '{8'hD0, octet_type'(8'hB0 + (r - 32))};
         else if (r < 64)  bytes = '{8'hD1, octet_type'(8'h80 + (r - 48))};
         else if (r == 64) bytes = '{8'hD0, 8'h81};
         else              bytes = '{8'hD1, 8'h91};
      end else if (kind < 60) begin
         bytes = '{rnd_octet(8'h7F)};
      end else if (kind < 68) begin
         // two-byte sequence with a random second byte, half the time on a letter lead byte
         if ($urandom_range(1)) bytes = '{rnd_octet(8'hD1, 8'hD0), rnd_octet(255)};
         else                   bytes = '{rnd_octet(8'hDF, 8'hC0), rnd_octet(255)};
      end else if (kind < 76) begin
         bytes = '{rnd_octet(8'hEF, 8'hE0), rnd_octet(255), rnd_octet(255)};
      end else if (kind < 84) begin
         bytes = '{rnd_octet(8'hF7, 8'hF0), rnd_octet(255), rnd_octet(255),
                   rnd_octet(255)};
      end else if (kind < 94) begin
         bytes = '{rnd_octet(255)};
      end else begin
         // truncated multi-byte character closed by end of text
         if ($urandom_range(1)) begin
            bytes = '{rnd_octet(8'hEF, 8'hE0)};
            conts = $urandom_range(1);
         end else begin
            bytes = '{rnd_octet(8'hF7, 8'hF0)};
            conts = $urandom_range(2);
         end
         repeat (conts) bytes.push_back(rnd_octet(8'hBF, 8'h80));
         eot_end = 1'b1;
      end
      foreach (bytes[k])
         send_byte(bytes[k], (k == bytes.size() - 1) ? eot_end : ($urandom_range(99) < 3));
   endtask

   // bit 8 is end of text
   logic [8:0] directed_items[] = '{
      9'h000, 9'h07F, 9'h080, 9'h0FF,          // zero byte, ASCII top, stray bytes
      9'h0D0, 9'h0A9, 9'h0D1, 9'h089,          // upper and lower shch
      9'h0D0, 9'h081, 9'h0D1, 9'h091,          // upper and lower yo
      9'h0D1, 9'h08C,                          // soft sign, no output
      9'h0E2, 9'h082, 9'h0AC,                  // three-byte passthrough
      9'h0F0, 9'h09F, 9'h098, 9'h080,          // four-byte passthrough
      9'h1D0,                                  // end of text on a lead byte
      9'h0F0, 9'h09F, 9'h198,                  // end of text inside four bytes
      9'h141                                   // end of text on a full character
   };

   initial begin
      sb = new();
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 18;
      recv_idle_pct = 75;
      foreach (directed_items[k])
         send_byte(directed_items[k][7:0], directed_items[k][8]);
      while (sent_cnt < directed_items.size() + PhaseItems) send_random_char();

      send_idle_pct = 75;
      recv_idle_pct = 18;
      while (sent_cnt < directed_items.size() + 2 * PhaseItems) send_random_char();

      // no idling; receiver stalls long enough for the input to back up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req      = HoldOffCycles;
      while (sent_cnt < directed_items.size() + 3 * PhaseItems) send_random_char();
      send_byte(rnd_octet(8'h7F), 1'b1);
      req_tvalid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/ctlt_pkg.sv
hw/rtl/ctlt_front.sv
hw/rtl/ctlt_queue.sv
hw/rtl/ctlt_back.sv
hw/rtl/cyrillic_latin_transliterator_core.sv
tb/cyrillic_latin_transliterator_core_tb.sv
